// File: design/fas_pkg.sv
// ----------------------------------------------------------------------------
// fas_pkg: shared types and constants for the fraction add/subtract block
// Beat structs for the request and response channels, field widths and the
// command codes.
// ----------------------------------------------------------------------------
package fas_pkg;

    // Width of a signed numerator operand; denominators are one bit narrower
    localparam int OPERAND_WIDTH = 16;
    localparam int RES_NUM_WIDTH = 32;
    localparam int RES_DEN_WIDTH = 30;

    // Command codes
    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_SUB = 1'b1;

    // One request beat: two fractions and the command
    typedef struct packed {
        logic                            cmd;
        logic signed [OPERAND_WIDTH-1:0] a_num;
        logic        [OPERAND_WIDTH-2:0] a_den;
        logic signed [OPERAND_WIDTH-1:0] b_num;
        logic        [OPERAND_WIDTH-2:0] b_den;
    } fas_req_t;

    // One response beat: reduced fraction
    typedef struct packed {
        logic signed [RES_NUM_WIDTH-1:0] res_num;
        logic        [RES_DEN_WIDTH-1:0] res_den;
    } fas_rsp_t;

endpackage

// File: design/fas_mul.sv
// ----------------------------------------------------------------------------
// fas_mul: registered signed multiplier
// One signed WIDTH x WIDTH product per cycle, registered: each result appears in the cycle after its operands.
// ----------------------------------------------------------------------------
module fas_mul #(
    parameter int WIDTH = fas_pkg::OPERAND_WIDTH
) (
    input  logic                      clk,
    input  logic signed [WIDTH-1:0]   a,
    input  logic signed [WIDTH-1:0]   b,
    output logic signed [2*WIDTH-1:0] p
);

    // Product register, no reset needed on payload
    always_ff @(posedge clk)
    begin
        p <= a * b;
    end

endmodule

// File: design/fas_addsub.sv
// ----------------------------------------------------------------------------
// fas_addsub: shared adder/subtractor
// Computes a + b or a - b in two's complement; the top bit of a difference of
// two nonnegative operands flags a borrow.
// ----------------------------------------------------------------------------
module fas_addsub #(
    parameter int WIDTH = 2 * fas_pkg::OPERAND_WIDTH + 1
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic             sub,
    output logic [WIDTH-1:0] y
);

    // Invert and carry in for subtraction
    assign y = a + (b ^ {WIDTH{sub}}) + WIDTH'(sub);

endmodule

// File: design/fraction_add_sub_reduce.sv
// ----------------------------------------------------------------------------
// fraction_add_sub_reduce: rational add/subtract with reduction to lowest terms
//
// Request channel (req_valid/req_ready/req_data) carries one beat with cmd,
// a_num/a_den and b_num/b_den. Response channel (rsp_valid/rsp_ready/rsp_data)
// returns one beat per request: res_num/res_den, reduced, sign on numerator.
// A zero numerator gives 0/1. req_ready is high only while the sequencer idles.
// Steps after the accepting edge, W = OPERAND_WIDTH: three multiply states,
// sum and magnitude, stripping of shared and then further factors of two,
// one gcd step per cycle (shift, swap or subtract) plus a finishing step,
// two restoring divisions of 2W quotient bits each and a sign step. A zero
// numerator skips the stripping, the gcd and the divisions. req_ready returns
// as the result is loaded, so a new request is taken only once the previous
// one is finished.
// The gcd loop and the divisions share one adder/subtractor, which sets the
// rate; the three products share one registered multiplier.
// The result sits in an output register; if the receiver still stalls when
// the next result is ready, the sequencer holds in its sign step.
// Reset (rst_n low, asynchronous) returns to idle and drops rsp_valid.
// ----------------------------------------------------------------------------
module fraction_add_sub_reduce (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  fas_pkg::fas_req_t req_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output fas_pkg::fas_rsp_t rsp_data
);

    localparam int W  = fas_pkg::OPERAND_WIDTH;
    localparam int MW = 2 * W;
    localparam int UW = MW + 1;
    localparam int CW = $clog2(MW + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_L,
        ST_MUL_R,
        ST_MUL_D,
        ST_ACC,
        ST_MAG,
        ST_STRIP2,
        ST_STRIPX,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_SIGN
    } state_t;

    state_t               state_reg, state_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    fas_pkg::fas_rsp_t    rsp_reg, rsp_next;
    fas_pkg::fas_req_t    req_reg, req_next;
    logic signed [MW-1:0] left_reg, left_next;
    logic signed [MW-1:0] right_reg, right_next;
    logic [MW-1:0]        den_reg, den_next;
    logic [MW-1:0]        num_reg, num_next;
    logic                 neg_reg, neg_next;
    logic [MW-1:0]        mag_reg, mag_next;
    logic [MW-1:0]        x_reg, x_next;
    logic [MW-1:0]        y_reg, y_next;
    logic [CW-1:0]        sh_reg, sh_next;
    logic [MW-1:0]        g_reg, g_next;
    logic [MW-1:0]        rem_reg, rem_next;
    logic [MW-1:0]        q_reg, q_next;
    logic [MW-1:0]        qn_reg, qn_next;
    logic [MW-1:0]        rd_reg, rd_next;
    logic [CW-1:0]        cnt_reg, cnt_next;

    logic signed [W-1:0]  mul_a, mul_b;
    logic signed [MW-1:0] mul_p;
    logic [UW-1:0]        au_a, au_b, au_y;
    logic                 au_sub;
    logic                 borrow;
    logic [UW-1:0]        div_shift;
    logic [MW-1:0]        div_q;
    logic                 div_last;
    logic signed [MW-1:0] rn_val;
    logic                 rsp_free;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    // Shared multiplier
    fas_mul #(.WIDTH(W)) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // Shared adder/subtractor
    fas_addsub #(.WIDTH(UW)) u_addsub (
        .a   (au_a),
        .b   (au_b),
        .sub (au_sub),
        .y   (au_y)
    );

    // Multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            ST_MUL_L:
            begin
                mul_a = req_reg.a_num;
                mul_b = signed'({1'b0, req_reg.b_den});
            end
            ST_MUL_R:
            begin
                mul_a = req_reg.b_num;
                mul_b = signed'({1'b0, req_reg.a_den});
            end
            default:
            begin
                mul_a = signed'({1'b0, req_reg.a_den});
                mul_b = signed'({1'b0, req_reg.b_den});
            end
        endcase
    end

    // Adder/subtractor operand select
    assign div_shift = {rem_reg, q_reg[MW-1]};

    always_comb
    begin
        au_a   = '0;
        au_b   = '0;
        au_sub = 1'b1;
        unique case (state_reg) inside
            ST_ACC:
            begin
                au_a   = {left_reg[MW-1], left_reg};
                au_b   = {right_reg[MW-1], right_reg};
                au_sub = (req_reg.cmd == fas_pkg::CMD_SUB);
            end
            ST_MAG:
            begin
                au_b = {num_reg[MW-1], num_reg};
            end
            ST_GCD:
            begin
                au_a = {1'b0, y_reg};
                au_b = {1'b0, x_reg};
            end
            ST_DIVN, ST_DIVD:
            begin
                au_a = div_shift;
                au_b = {1'b0, g_reg};
            end
            ST_SIGN:
            begin
                au_b = {1'b0, qn_reg};
            end
            default:
            begin
                au_sub = 1'b1;
            end
        endcase
    end

    assign borrow   = au_y[UW-1];
    assign div_q    = {q_reg[MW-2:0], ~borrow};
    assign div_last = (cnt_reg == CW'(MW - 1));
    assign rn_val   = signed'(neg_reg ? au_y[MW-1:0] : qn_reg);

    // Sequencer next-state and datapath next values
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        req_next       = req_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        den_next       = den_reg;
        num_next       = num_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        sh_next        = sh_reg;
        g_next         = g_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        qn_next        = qn_reg;
        rd_next        = rd_reg;
        cnt_next       = cnt_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg) inside
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req_data;
                    state_next = ST_MUL_L;
                end
            end
            ST_MUL_L:
            begin
                state_next = ST_MUL_R;
            end
            ST_MUL_R:
            begin
                left_next  = mul_p;
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                right_next = mul_p;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                den_next   = unsigned'(mul_p);
                num_next   = au_y[MW-1:0];
                state_next = ST_MAG;
            end
            ST_MAG:
            begin
                // Zero numerator goes straight to 0/1
                if (num_reg == '0)
                begin
                    neg_next   = 1'b0;
                    qn_next    = '0;
                    rd_next    = MW'(1);
                    state_next = ST_SIGN;
                end
                else
                begin
                    neg_next   = num_reg[MW-1];
                    mag_next   = num_reg[MW-1] ? au_y[MW-1:0] : num_reg;
                    x_next     = num_reg[MW-1] ? au_y[MW-1:0] : num_reg;
                    y_next     = den_reg;
                    sh_next    = '0;
                    state_next = ST_STRIP2;
                end
            end
            ST_STRIP2:
            begin
                // Remove common factors of two
                if (!x_reg[0] && !y_reg[0])
                begin
                    x_next  = x_reg >> 1;
                    y_next  = y_reg >> 1;
                    sh_next = sh_reg + CW'(1);
                end
                else
                begin
                    state_next = ST_STRIPX;
                end
            end
            ST_STRIPX:
            begin
                if (!x_reg[0])
                begin
                    x_next = x_reg >> 1;
                end
                else
                begin
                    state_next = ST_GCD;
                end
            end
            ST_GCD:
            begin
                // x stays odd; shift y, swap when x > y, else y -= x
                if (y_reg == '0)
                begin
                    g_next     = x_reg << sh_reg;
                    rem_next   = '0;
                    q_next     = mag_reg;
                    cnt_next   = '0;
                    state_next = ST_DIVN;
                end
                else if (!y_reg[0])
                begin
                    y_next = y_reg >> 1;
                end
                else if (borrow)
                begin
                    x_next = y_reg;
                    y_next = x_reg;
                end
                else
                begin
                    y_next = au_y[MW-1:0];
                end
            end
            ST_DIVN, ST_DIVD:
            begin
                // One restoring quotient bit per cycle
                rem_next = borrow ? div_shift[MW-1:0] : au_y[MW-1:0];
                q_next   = div_q;
                cnt_next = cnt_reg + CW'(1);
                if (div_last)
                begin
                    rem_next = '0;
                    cnt_next = '0;
                    if (state_reg == ST_DIVN)
                    begin
                        qn_next    = div_q;
                        q_next     = den_reg;
                        state_next = ST_DIVD;
                    end
                    else
                    begin
                        rd_next    = div_q;
                        state_next = ST_SIGN;
                    end
                end
            end
            ST_SIGN:
            begin
                // Apply sign and load the output register when it is free
                if (rsp_free)
                begin
                    rsp_next.res_num = fas_pkg::RES_NUM_WIDTH'(rn_val);
                    rsp_next.res_den = fas_pkg::RES_DEN_WIDTH'(rd_reg);
                    rsp_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        den_reg   <= den_next;
        num_reg   <= num_next;
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        sh_reg    <= sh_next;
        g_reg     <= g_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        qn_reg    <= qn_next;
        rd_reg    <= rd_next;
        cnt_reg   <= cnt_next;
    end

    // Checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req_ready high right after an accepted beat");

    a_gcd_x_odd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_GCD |-> x_reg[0])
        else $error("gcd operand x not odd");

    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVN || state_reg == ST_DIVD) |-> rem_reg < g_reg)
        else $error("division remainder not below divisor");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVN || state_reg == ST_DIVD) |-> g_reg != '0)
        else $error("division by zero gcd");

    a_sign_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SIGN && rsp_free |=> rsp_valid && req_ready)
        else $error("result not posted after sign step");

endmodule

// File: tb/sv/fraction_add_sub_reduce_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_add_sub_reduce_tb: self-checking bench for the fraction add/sub block
// Walks a short table of directed fraction pairs, then a long random run.
// Beats with no known table result are scored by an in-bench model that forms
// the cross products and reduces by the gcd. Response beats are compared in
// order. Both sides idle at random, with some stretches where they do not idle.
// ----------------------------------------------------------------------------
module fraction_add_sub_reduce_tb;

    localparam int RANDOM_ITEMS = 1626;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 300;

    typedef logic signed [fas_pkg::OPERAND_WIDTH-1:0] num_t;
    typedef logic        [fas_pkg::OPERAND_WIDTH-2:0] den_t;

    // One directed row; want_* is used only when known is set
    typedef struct {
        logic cmd;
        int   an;
        int   ad;
        int   bn;
        int   bd;
        bit   known;
        int   want_num;
        int   want_den;
    } fraction_row_t;

    localparam int PLAN_LEN = 24;

    // Directed table: cmd, a_num, a_den, b_num, b_den, known, res_num, res_den
    fraction_row_t plan [PLAN_LEN] = '{
        '{fas_pkg::CMD_ADD,      0,     1,      0,     1, 1'b1,      0, 1},
        '{fas_pkg::CMD_ADD,      1,     2,      1,     2, 1'b1,      1, 1},
        '{fas_pkg::CMD_SUB,      1,     2,      1,     2, 1'b1,      0, 1},
        '{fas_pkg::CMD_ADD,      1,     3,      1,     6, 1'b1,      1, 2},
        '{fas_pkg::CMD_SUB,      6,     4,      1,     4, 1'b1,      5, 4},
        '{fas_pkg::CMD_ADD,      1,  1024,      1,  1024, 1'b1,      1, 512},
        '{fas_pkg::CMD_ADD, -32768,     1, -32768,     1, 1'b1, -65536, 1},
        '{fas_pkg::CMD_SUB,  32767,     1, -32768,     1, 1'b1,  65535, 1},
        '{fas_pkg::CMD_SUB, -32768,     1,  32767,     1, 1'b1, -65535, 1},
        '{fas_pkg::CMD_ADD,  32767, 32767,  32767, 32767, 1'b1,      2, 1},
        '{fas_pkg::CMD_SUB, -32768, 32767,  32767, 32767, 1'b1, -65535, 32767},
        '{fas_pkg::CMD_ADD, -32768, 32767, -32768, 32767, 1'b1, -65536, 32767},
        '{fas_pkg::CMD_ADD, -32768,     1, -32768, 32767, 1'b1, -1073741824, 32767},
        '{fas_pkg::CMD_ADD,      1, 32767,      1, 32765, 1'b0,      0, 0},
        '{fas_pkg::CMD_SUB, -32768, 32767,  32767, 32766, 1'b0,      0, 0},
        // zero denominators: nonzero numerator collapses to +-1/0
        '{fas_pkg::CMD_ADD,      5,     0,      3,     7, 1'b1,      1, 0},
        '{fas_pkg::CMD_ADD,     -5,     0,      3,     7, 1'b1,     -1, 0},
        '{fas_pkg::CMD_SUB,      3,     7,      2,     0, 1'b1,     -1, 0},
        '{fas_pkg::CMD_SUB,      4,     0,      3,     0, 1'b1,      0, 1},
        '{fas_pkg::CMD_ADD,      0,     0,      0,     0, 1'b1,      0, 1},
        '{fas_pkg::CMD_ADD,     -1, 32767,      1, 32767, 1'b1,      0, 1},
        '{fas_pkg::CMD_SUB,  12345, 32767,   -321,    17, 1'b0,      0, 0},
        '{fas_pkg::CMD_ADD,      0, 32767,     -7,     3, 1'b1,     -7, 3},
        '{fas_pkg::CMD_ADD,  32767,     1,  32767,     1, 1'b1,  65534, 1}
    };

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    fas_pkg::fas_req_t  req_data  = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    fas_pkg::fas_rsp_t  rsp_data;

    fas_pkg::fas_rsp_t  expected_sums [$];
    int                 error_count = 0;
    int                 quiet_cycles = 0;
    bit                 steady = 1'b0;

    fraction_add_sub_reduce dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    always #5 clk = ~clk;

    // Euclid; a zero second argument returns the first
    function automatic longint greatest_divisor(input longint x, input longint y);
        longint t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Cross-multiply, then divide both terms by the gcd of their magnitudes
    function automatic fas_pkg::fas_rsp_t sum_in_lowest_terms(input fas_pkg::fas_req_t q);
        longint            an, ad, bn, bd, num, den, mag, g, rn, rd;
        fas_pkg::fas_rsp_t r;
        an  = longint'($signed(q.a_num));
        bn  = longint'($signed(q.b_num));
        ad  = longint'(q.a_den);
        bd  = longint'(q.b_den);
        num = (q.cmd == fas_pkg::CMD_SUB) ? (an * bd - bn * ad) : (an * bd + bn * ad);
        den = ad * bd;
        mag = (num < 0) ? -num : num;
        if (mag == 0) begin
            rn = 0;
            rd = 1;
        end else begin
            g  = greatest_divisor(mag, den);
            rn = (num < 0) ? -(mag / g) : (mag / g);
            rd = den / g;
        end
        r.res_num = rn[fas_pkg::RES_NUM_WIDTH-1:0];
        r.res_den = rd[fas_pkg::RES_DEN_WIDTH-1:0];
        return r;
    endfunction

    function automatic int idle_draw();
        return steady ? 0 : int'($urandom_range(0, 4));
    endfunction

    function automatic num_t pick_num();
        case ($urandom_range(0, 7)) inside
            0: begin
                case ($urandom_range(0, 4))
                    0: return num_t'(-32768);
                    1: return num_t'(32767);
                    2: return num_t'(0);
                    3: return num_t'(-1);
                    default: return num_t'(1);
                endcase
            end
            1, 2: return num_t'(int'($urandom_range(0, 40)) - 20);
            default: return num_t'($urandom);
        endcase
    endfunction

    function automatic den_t pick_den();
        case ($urandom_range(0, 31)) inside
            0: return den_t'(0);
            1, 2: return den_t'(32767);
            [3:5]: return den_t'(1 << $urandom_range(0, 14));
            [6:11]: return den_t'($urandom_range(1, 24));
            default: return den_t'($urandom_range(1, 32767));
        endcase
    endfunction

    // Random pair, biased toward shared factors so reduction has work to do
    function automatic fas_pkg::fas_req_t random_pair();
        fas_pkg::fas_req_t q;
        q.cmd   = ($urandom_range(0, 1) == 0) ? fas_pkg::CMD_ADD : fas_pkg::CMD_SUB;
        q.a_num = pick_num();
        q.a_den = pick_den();
        q.b_num = pick_num();
        case ($urandom_range(0, 7))
            0: q.b_den = q.a_den;
            1: q.b_den = den_t'(q.a_den * $urandom_range(1, 4));
            2: begin
                q.b_num = q.a_num;
                q.b_den = q.a_den;
            end
            default: q.b_den = pick_den();
        endcase
        return q;
    endfunction

    // Present one request beat, hold it until taken, then queue its result
    task automatic offer_fractions(input fas_pkg::fas_req_t q, input fas_pkg::fas_rsp_t want);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= q;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        expected_sums.push_back(want);
    endtask

    // Stimulus
    initial begin
        fas_pkg::fas_req_t q;
        fas_pkg::fas_rsp_t want;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i]) begin
            q.cmd   = plan[i].cmd;
            q.a_num = num_t'(plan[i].an);
            q.a_den = den_t'(plan[i].ad);
            q.b_num = num_t'(plan[i].bn);
            q.b_den = den_t'(plan[i].bd);
            if (plan[i].known) begin
                want.res_num = plan[i].want_num[fas_pkg::RES_NUM_WIDTH-1:0];
                want.res_den = plan[i].want_den[fas_pkg::RES_DEN_WIDTH-1:0];
            end else begin
                want = sum_in_lowest_terms(q);
            end
            offer_fractions(q, want);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // switch between idling and back-to-back stretches
            if (n % 64 == 0) steady = ($urandom_range(0, 3) == 0);
            q = random_pair();
            offer_fractions(q, sum_in_lowest_terms(q));
        end
        req_valid <= 1'b0;

        while (expected_sums.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Response side: random back-pressure, in-order compare per beat
    initial begin
        int                stall;
        fas_pkg::fas_rsp_t want;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = idle_draw();
            if (stall > 0) begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
            if (expected_sums.size() == 0) begin
                $display("%0t unexpected result beat: res_num %0d res_den %0d",
                         $time, rsp_data.res_num, rsp_data.res_den);
                error_count++;
            end else begin
                want = expected_sums.pop_front();
                if (rsp_data.res_num !== want.res_num) begin
                    $display("%0t res_num mismatch: expected %0d actual %0d",
                             $time, want.res_num, rsp_data.res_num);
                    error_count++;
                end
                if (rsp_data.res_den !== want.res_den) begin
                    $display("%0t res_den mismatch: expected %0d actual %0d",
                             $time, want.res_den, rsp_data.res_den);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: too long without any beat on either channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t no beat for %0d cycles", $time, STALL_LIMIT);
                $display("FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

endmodule

// File: files.f
design/fas_pkg.sv
design/fas_mul.sv
design/fas_addsub.sv
design/fraction_add_sub_reduce.sv
tb/sv/fraction_add_sub_reduce_tb.sv
